// ----- rtl/core/ftcl_pkg.sv -----
// Package for the frame tree chain lookup block.
// Holds the shared types, codes and the command and status structs.
// No dependencies.
package ftcl_pkg;

  localparam int unsigned FrameW = 8;

  typedef logic [FrameW-1:0] frame_t;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic SIDE_SRC = 1'b0;
  localparam logic SIDE_TGT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FRAME_ZERO,
    ST_TOO_DEEP,
    ST_NO_ROOT
  } ftcl_status_e;

  typedef enum logic [1:0] {
    KIND_SRC,
    KIND_TGT,
    KIND_STATUS
  } ftcl_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_SRC,
    S_WALK_SRC,
    S_LOAD_SRC,
    S_CHK_TGT,
    S_WALK_TGT,
    S_LOAD_TGT,
    S_ROOT_RD,
    S_ROOT_CMP,
    S_STRIP_RD,
    S_STRIP_CMP,
    S_EMIT_CHK,
    S_EMIT_RD,
    S_EMIT_OUT
  } ftcl_state_e;

  typedef struct packed {
    logic         accept_set;
    logic         accept_get;
    logic         side;
    logic         walk_init;
    logic         walk_step;
    logic         walk_load;
    logic         walk_done;
    logic         strip_dec;
    logic         emit_init;
    logic         emit_rd;
    logic         emit_out;
    logic         stat_out;
    ftcl_status_e stat_code;
  } ftcl_cmd_t;

  typedef struct packed {
    logic src_zero;
    logic tgt_zero;
    logic cur_zero;
    logic n_full;
    logic tails_eq;
    logic sl_zero;
    logic tl_zero;
    logic emit_last;
  } ftcl_sts_t;

endpackage

// ----- rtl/core/ftcl_ctrl.sv -----
// Controller state machine of the frame tree chain lookup block.
// Sequences the two walks, the tail strip and the emission of words.
// Depends on ftcl_pkg.
module ftcl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  operation_i,
  output logic                  busy_o,
  output ftcl_pkg::ftcl_cmd_t   cmd_o,
  input  ftcl_pkg::ftcl_sts_t   sts_i
);
  import ftcl_pkg::*;

  ftcl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && (operation_i == OP_LOOKUP)) state_d = S_CHK_SRC;
      end
      S_CHK_SRC: state_d = sts_i.src_zero ? S_IDLE : S_WALK_SRC;
      S_WALK_SRC: begin
        if (sts_i.cur_zero) state_d = S_CHK_TGT;
        else if (sts_i.n_full) state_d = S_IDLE;
        else state_d = S_LOAD_SRC;
      end
      S_LOAD_SRC: state_d = S_WALK_SRC;
      S_CHK_TGT: state_d = sts_i.tgt_zero ? S_IDLE : S_WALK_TGT;
      S_WALK_TGT: begin
        if (sts_i.cur_zero) state_d = S_ROOT_RD;
        else if (sts_i.n_full) state_d = S_IDLE;
        else state_d = S_LOAD_TGT;
      end
      S_LOAD_TGT: state_d = S_WALK_TGT;
      S_ROOT_RD: state_d = S_ROOT_CMP;
      S_ROOT_CMP: state_d = sts_i.tails_eq ? S_STRIP_RD : S_IDLE;
      S_STRIP_RD: state_d = (sts_i.sl_zero || sts_i.tl_zero) ? S_EMIT_CHK : S_STRIP_CMP;
      S_STRIP_CMP: state_d = sts_i.tails_eq ? S_STRIP_RD : S_EMIT_CHK;
      S_EMIT_CHK: state_d = (sts_i.sl_zero && sts_i.tl_zero) ? S_IDLE : S_EMIT_RD;
      S_EMIT_RD: state_d = S_EMIT_OUT;
      S_EMIT_OUT: state_d = sts_i.emit_last ? S_IDLE : S_EMIT_RD;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.stat_code = ST_OK;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept_set = start_i && (operation_i == OP_SET);
        cmd_o.accept_get = start_i && (operation_i == OP_LOOKUP);
      end
      S_CHK_SRC: begin
        cmd_o.side = SIDE_SRC;
        if (sts_i.src_zero) begin
          cmd_o.stat_out  = 1'b1;
          cmd_o.stat_code = ST_FRAME_ZERO;
        end else begin
          cmd_o.walk_init = 1'b1;
        end
      end
      S_WALK_SRC, S_WALK_TGT: begin
        cmd_o.side = (state_q == S_WALK_TGT) ? SIDE_TGT : SIDE_SRC;
        if (sts_i.cur_zero) begin
          cmd_o.walk_done = 1'b1;
        end else if (sts_i.n_full) begin
          cmd_o.stat_out  = 1'b1;
          cmd_o.stat_code = ST_TOO_DEEP;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_LOAD_SRC, S_LOAD_TGT: begin
        cmd_o.walk_load = 1'b1;
      end
      S_CHK_TGT: begin
        cmd_o.side = SIDE_TGT;
        if (sts_i.tgt_zero) begin
          cmd_o.stat_out  = 1'b1;
          cmd_o.stat_code = ST_FRAME_ZERO;
        end else begin
          cmd_o.walk_init = 1'b1;
        end
      end
      S_ROOT_CMP: begin
        if (sts_i.tails_eq) begin
          cmd_o.strip_dec = 1'b1;
        end else begin
          cmd_o.stat_out  = 1'b1;
          cmd_o.stat_code = ST_NO_ROOT;
        end
      end
      S_STRIP_CMP: begin
        cmd_o.strip_dec = sts_i.tails_eq;
      end
      S_EMIT_CHK: begin
        if (sts_i.sl_zero && sts_i.tl_zero) begin
          cmd_o.stat_out  = 1'b1;
          cmd_o.stat_code = ST_OK;
        end else begin
          cmd_o.emit_init = 1'b1;
        end
      end
      S_EMIT_RD: cmd_o.emit_rd = 1'b1;
      S_EMIT_OUT: cmd_o.emit_out = 1'b1;
      default: begin
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ----- rtl/core/ftcl_dp.sv -----
// Datapath of the frame tree chain lookup block.
// Holds the parent table, both chain memories, the counters and the result register.
// Depends on ftcl_pkg.
module ftcl_dp #(
  parameter int unsigned NUM_FRAMES = 256,
  parameter int unsigned MAX_DEPTH  = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ftcl_pkg::ftcl_cmd_t    cmd_i,
  output ftcl_pkg::ftcl_sts_t    sts_o,
  input  ftcl_pkg::frame_t       frame_id_i,
  input  ftcl_pkg::frame_t       parent_id_i,
  input  ftcl_pkg::frame_t       target_id_i,
  output logic                   out_valid_o,
  output ftcl_pkg::ftcl_kind_e   kind_o,
  output ftcl_pkg::frame_t       chain_frame_o,
  output ftcl_pkg::ftcl_status_e status_o,
  output logic                   last_o
);
  import ftcl_pkg::*;

  localparam int unsigned TblDepth = (NUM_FRAMES < 256) ? NUM_FRAMES : 256;
  localparam int unsigned TblAw    = $clog2(TblDepth);
  localparam int unsigned Cap      = MAX_DEPTH + 1;
  localparam int unsigned CapAw    = $clog2(Cap);
  localparam int unsigned LenW     = $clog2(Cap + 1);
  localparam logic [LenW-1:0] LenOne = LenW'(1);
  localparam logic [LenW-1:0] LenCap = LenW'(Cap);

  frame_t            tbl_mem [TblDepth];
  logic [TblDepth-1:0] tbl_vld_q;
  frame_t            tbl_rd_q;
  logic              tbl_hit_q;
  logic [TblAw-1:0]  wr_idx, rd_idx;
  logic              wr_en, rd_in_range;
  frame_t            parent;

  frame_t            src_mem [Cap];
  frame_t            tgt_mem [Cap];
  frame_t            src_rd_q, tgt_rd_q;
  logic [CapAw-1:0]  src_raddr, tgt_raddr, n_idx;

  frame_t            src_q, src_d, tgt_q, tgt_d, cur_q, cur_d;
  logic [LenW-1:0]   n_q, n_d, sl_q, sl_d, tl_q, tl_d, i_q, i_d;
  logic [LenW-1:0]   sl_m1, tl_m1, i_inc;
  logic              side_q, side_d;
  logic              emit_last;

  logic              out_vld_q, out_vld_d, last_q, last_d;
  ftcl_kind_e        kind_q, kind_d;
  frame_t            frame_q, frame_d;
  ftcl_status_e      status_q, status_d;

  // Parent table: valid bits make never-written entries read as no parent.
  assign wr_idx      = frame_id_i[TblAw-1:0];
  assign wr_en       = cmd_i.accept_set && (32'(frame_id_i) < NUM_FRAMES);
  assign rd_idx      = cur_q[TblAw-1:0];
  assign rd_in_range = (32'(cur_q) < NUM_FRAMES);
  assign parent      = tbl_hit_q ? tbl_rd_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem[wr_idx] <= parent_id_i;
    end
    tbl_rd_q <= tbl_mem[rd_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
      tbl_hit_q <= 1'b0;
    end else begin
      if (wr_en) begin
        tbl_vld_q[wr_idx] <= 1'b1;
      end
      tbl_hit_q <= tbl_vld_q[rd_idx] && rd_in_range;
    end
  end

  // Chain memories.
  assign sl_m1     = sl_q - LenOne;
  assign tl_m1     = tl_q - LenOne;
  assign i_inc     = i_q + LenOne;
  assign n_idx     = n_q[CapAw-1:0];
  assign src_raddr = cmd_i.emit_rd ? i_q[CapAw-1:0] : sl_m1[CapAw-1:0];
  assign tgt_raddr = cmd_i.emit_rd ? i_q[CapAw-1:0] : tl_m1[CapAw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step && (cmd_i.side == SIDE_SRC)) begin
      src_mem[n_idx] <= cur_q;
    end
    src_rd_q <= src_mem[src_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_step && (cmd_i.side == SIDE_TGT)) begin
      tgt_mem[n_idx] <= cur_q;
    end
    tgt_rd_q <= tgt_mem[tgt_raddr];
  end

  assign emit_last = (side_q == SIDE_TGT) ? (i_inc == tl_q)
                                          : ((i_inc == sl_q) && (tl_q == '0));

  always_comb begin
    src_d     = src_q;
    tgt_d     = tgt_q;
    cur_d     = cur_q;
    n_d       = n_q;
    sl_d      = sl_q;
    tl_d      = tl_q;
    i_d       = i_q;
    side_d    = side_q;
    out_vld_d = 1'b0;
    kind_d    = kind_q;
    frame_d   = frame_q;
    status_d  = status_q;
    last_d    = last_q;

    if (cmd_i.accept_get) begin
      src_d = frame_id_i;
      tgt_d = target_id_i;
    end
    if (cmd_i.walk_init) begin
      cur_d = (cmd_i.side == SIDE_TGT) ? tgt_q : src_q;
      n_d   = '0;
    end
    if (cmd_i.walk_step) begin
      n_d = n_q + LenOne;
    end
    if (cmd_i.walk_load) begin
      cur_d = parent;
    end
    if (cmd_i.walk_done) begin
      if (cmd_i.side == SIDE_TGT) begin
        tl_d = n_q;
      end else begin
        sl_d = n_q;
      end
    end
    if (cmd_i.strip_dec) begin
      sl_d = sl_m1;
      tl_d = tl_m1;
    end
    if (cmd_i.emit_init) begin
      side_d = (sl_q == '0) ? SIDE_TGT : SIDE_SRC;
      i_d    = '0;
    end
    if (cmd_i.emit_out) begin
      out_vld_d = 1'b1;
      kind_d    = (side_q == SIDE_TGT) ? KIND_TGT : KIND_SRC;
      frame_d   = (side_q == SIDE_TGT) ? tgt_rd_q : src_rd_q;
      status_d  = ST_OK;
      last_d    = emit_last;
      if ((side_q == SIDE_SRC) && (i_inc == sl_q)) begin
        side_d = SIDE_TGT;
        i_d    = '0;
      end else begin
        i_d = i_inc;
      end
    end
    if (cmd_i.stat_out) begin
      out_vld_d = 1'b1;
      kind_d    = KIND_STATUS;
      frame_d   = '0;
      status_d  = cmd_i.stat_code;
      last_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sl_q      <= '0;
      tl_q      <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      sl_q      <= sl_d;
      tl_q      <= tl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q    <= src_d;
    tgt_q    <= tgt_d;
    cur_q    <= cur_d;
    n_q      <= n_d;
    i_q      <= i_d;
    side_q   <= side_d;
    kind_q   <= kind_d;
    frame_q  <= frame_d;
    status_q <= status_d;
    last_q   <= last_d;
  end

  assign sts_o.src_zero  = (src_q == '0);
  assign sts_o.tgt_zero  = (tgt_q == '0);
  assign sts_o.cur_zero  = (cur_q == '0);
  assign sts_o.n_full    = (n_q == LenCap);
  assign sts_o.tails_eq  = (src_rd_q == tgt_rd_q);
  assign sts_o.sl_zero   = (sl_q == '0);
  assign sts_o.tl_zero   = (tl_q == '0);
  assign sts_o.emit_last = emit_last;

  assign out_valid_o   = out_vld_q;
  assign kind_o        = kind_q;
  assign chain_frame_o = frame_q;
  assign status_o      = status_q;
  assign last_o        = last_q;

  a_step_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk_step |-> n_q != LenCap)
    else $error("Chain written beyond its capacity.");

  a_strip_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.strip_dec |-> (sl_q != '0) && (tl_q != '0))
    else $error("Strip on an empty chain.");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_out |-> ((side_q == SIDE_SRC) ? (i_q < sl_q) : (i_q < tl_q)))
    else $error("Emitted entry lies beyond the chain length.");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (kind_q == KIND_STATUS)) |-> last_q)
    else $error("Status word without last flag.");

  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (kind_q != KIND_STATUS)) |-> (status_q == ST_OK))
    else $error("Chain entry word with error status.");

endmodule

// ----- rtl/core/frame_tree_chain_lookup.sv -----
// Lookup: walks the source chain and the target chain, strips the shared tail, then
// emits the remaining words; a set item gives no result.
// Each parent link is followed through the registered table read; each emitted word is read
// through the single read port of its chain memory. One item at a time.
// Result words are strobed for one cycle each and cannot be held off by the receiver.
// Reset is asynchronous; the parent table reads as all zero right after reset.
module frame_tree_chain_lookup #(
  parameter int unsigned NUM_FRAMES = 256,
  parameter int unsigned MAX_DEPTH  = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation_i,
  input  ftcl_pkg::frame_t       frame_id_i,
  input  ftcl_pkg::frame_t       parent_id_i,
  input  ftcl_pkg::frame_t       target_id_i,
  output logic                   out_valid_o,
  output ftcl_pkg::ftcl_kind_e   kind_o,
  output ftcl_pkg::frame_t       chain_frame_o,
  output ftcl_pkg::ftcl_status_e status_o,
  output logic                   last_o
);
  import ftcl_pkg::*;

  ftcl_cmd_t cmd;
  ftcl_sts_t sts;

  ftcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .operation_i (operation_i),
    .busy_o      (busy),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ftcl_dp #(
    .NUM_FRAMES (NUM_FRAMES),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .frame_id_i    (frame_id_i),
    .parent_id_i   (parent_id_i),
    .target_id_i   (target_id_i),
    .out_valid_o   (out_valid_o),
    .kind_o        (kind_o),
    .chain_frame_o (chain_frame_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

endmodule

// ----- sim/tb_frame_tree_chain_lookup.sv -----
`timescale 1ns / 1ps
// Testbench for frame_tree_chain_lookup: builds random frame trees, chains and loops, then
// checks every result word against a parent table kept in a scoreboard class.
// Depends on ftcl_pkg and the frame_tree_chain_lookup RTL.
module tb_frame_tree_chain_lookup;
  import ftcl_pkg::*;

  localparam int unsigned NumFrames  = 256;
  localparam int unsigned MaxDepth   = 30;
  localparam int unsigned ChainCap   = MaxDepth + 1;
  localparam int unsigned ItemTarget = 420;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainWait  = 340;

  typedef struct packed {
    ftcl_kind_e   kind;
    frame_t       frame;
    ftcl_status_e status;
    logic         last;
  } chain_res_t;

  class chain_board;
    frame_t       parent_tbl[NumFrames];
    frame_t       chain[2][ChainCap];
    int unsigned  chain_len[2];
    chain_res_t   path_q[$];
    int unsigned  errors;

    function new();
      foreach (parent_tbl[i]) parent_tbl[i] = '0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return path_q.size();
    endfunction

    function void push_res(ftcl_kind_e kind, frame_t frame, ftcl_status_e status, logic last);
      chain_res_t r;
      r.kind   = kind;
      r.frame  = frame;
      r.status = status;
      r.last   = last;
      path_q = {path_q, r};
    endfunction

    function ftcl_status_e walk_up(logic side, frame_t from);
      frame_t      cur;
      int unsigned n;
      cur = from;
      n   = 0;
      while (cur != '0) begin
        if (n >= ChainCap) begin
          chain_len[side] = n;
          return ST_TOO_DEEP;
        end
        chain[side][n] = cur;
        n++;
        cur = parent_tbl[cur];
      end
      chain_len[side] = n;
      return ST_OK;
    endfunction

    function void note_word(logic op, frame_t src, frame_t par, frame_t tgt);
      ftcl_status_e st;
      int unsigned  sl;
      int unsigned  tl;
      int unsigned  total;
      int unsigned  k;
      if (op == OP_SET) begin
        parent_tbl[src] = par;
        return;
      end
      if (src == '0) begin
        push_res(KIND_STATUS, '0, ST_FRAME_ZERO, 1'b1);
        return;
      end
      st = walk_up(SIDE_SRC, src);
      if (st != ST_OK) begin
        push_res(KIND_STATUS, '0, st, 1'b1);
        return;
      end
      if (tgt == '0) begin
        push_res(KIND_STATUS, '0, ST_FRAME_ZERO, 1'b1);
        return;
      end
      st = walk_up(SIDE_TGT, tgt);
      if (st != ST_OK) begin
        push_res(KIND_STATUS, '0, st, 1'b1);
        return;
      end
      sl = chain_len[SIDE_SRC];
      tl = chain_len[SIDE_TGT];
      if (chain[SIDE_SRC][sl-1] != chain[SIDE_TGT][tl-1]) begin
        push_res(KIND_STATUS, '0, ST_NO_ROOT, 1'b1);
        return;
      end
      while (sl > 0 && tl > 0 && chain[SIDE_SRC][sl-1] == chain[SIDE_TGT][tl-1]) begin
        sl--;
        tl--;
      end
      total = sl + tl;
      if (total == 0) begin
        push_res(KIND_STATUS, '0, ST_OK, 1'b1);
        return;
      end
      k = 0;
      for (int unsigned i = 0; i < sl; i++) begin
        push_res(KIND_SRC, chain[SIDE_SRC][i], ST_OK, k == total - 1);
        k++;
      end
      for (int unsigned i = 0; i < tl; i++) begin
        push_res(KIND_TGT, chain[SIDE_TGT][i], ST_OK, k == total - 1);
        k++;
      end
    endfunction

    function void check_word(logic [1:0] kind, frame_t frame, logic [1:0] status, logic last);
      chain_res_t want;
      if (path_q.size() == 0) begin
        $error("unexpected result word: kind %0d, chain_frame %0d, status %0d, last %0d",
               kind, frame, status, last);
        errors++;
        return;
      end
      want = path_q.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        errors++;
      end
      if (frame !== want.frame) begin
        $error("chain_frame: expected %0d, actual %0d", want.frame, frame);
        errors++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni      = 1'b0;
  logic         start       = 1'b0;
  logic         busy;
  logic         operation_i = OP_SET;
  frame_t       frame_id_i  = '0;
  frame_t       parent_id_i = '0;
  frame_t       target_id_i = '0;
  logic         out_valid_o;
  ftcl_kind_e   kind_o;
  frame_t       chain_frame_o;
  ftcl_status_e status_o;
  logic         last_o;

  chain_board   board;
  frame_t       nodes[$];
  int unsigned  items_sent = 0;
  int unsigned  cycle_count = 0;
  bit           no_gaps = 1'b0;

  frame_tree_chain_lookup #(
    .NUM_FRAMES(NumFrames),
    .MAX_DEPTH (MaxDepth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .frame_id_i   (frame_id_i),
    .parent_id_i  (parent_id_i),
    .target_id_i  (target_id_i),
    .out_valid_o  (out_valid_o),
    .kind_o       (kind_o),
    .chain_frame_o(chain_frame_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1) begin
      board.check_word(kind_o, chain_frame_o, status_o, last_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic op, input frame_t f, input frame_t p, input frame_t t);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       = 1'b1;
    operation_i = op;
    frame_id_i  = f;
    parent_id_i = p;
    target_id_i = t;
    forever begin
      @(posedge clk_i);
      if (busy === 1'b0) break;
    end
    board.note_word(op, f, p, t);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic set_parent(input frame_t f, input frame_t p);
    send_word(OP_SET, f, p, frame_t'($urandom));
  endtask

  task automatic lookup(input frame_t s, input frame_t t);
    send_word(OP_LOOKUP, s, frame_t'($urandom), t);
  endtask

  task automatic drain();
    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void claim_nodes(int unsigned n);
    bit     taken[NumFrames];
    frame_t id;
    nodes.delete();
    foreach (taken[i]) taken[i] = 1'b0;
    taken[0] = 1'b1;
    while (nodes.size() < n) begin
      id = frame_t'($urandom_range(1, NumFrames - 1));
      if (!taken[id]) begin
        taken[id] = 1'b1;
        nodes = {nodes, id};
      end
    end
  endfunction

  function automatic frame_t pick_node();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6 || nodes.size() == 0) return '0;
    if (r < 14) return frame_t'($urandom);
    return nodes[$urandom_range(0, nodes.size() - 1)];
  endfunction

  task automatic grow_tree(input int unsigned n);
    frame_t up;
    claim_nodes(n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 4) == 0) up = '0;
      else up = nodes[$urandom_range(0, i - 1)];
      set_parent(nodes[i], up);
    end
  endtask

  // Two arms of la and lb frames hanging from one root.
  task automatic grow_vee(input int unsigned la, input int unsigned lb);
    claim_nodes(1 + la + lb);
    set_parent(nodes[0], '0);
    for (int unsigned i = 1; i <= la + lb; i++) begin
      set_parent(nodes[i], (i == 1 || i == la + 1) ? nodes[0] : nodes[i-1]);
    end
    lookup(nodes[la], nodes[la+lb]);
    lookup(nodes[la+lb], nodes[la]);
    lookup(nodes[la], nodes[0]);
    lookup(pick_node(), pick_node());
  endtask

  initial begin
    int unsigned r;
    int unsigned episode;
    board = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    lookup(8'd0, 8'd5);
    lookup(8'd5, 8'd0);
    lookup(8'd5, 8'd5);
    lookup(8'd5, 8'd6);
    set_parent(8'd5, 8'd255);
    set_parent(8'd6, 8'd255);
    set_parent(8'd255, 8'd0);
    lookup(8'd5, 8'd6);
    lookup(8'd5, 8'd255);
    lookup(8'd255, 8'd6);
    lookup(8'd6, 8'd6);
    set_parent(8'd255, 8'd255);
    lookup(8'd5, 8'd6);
    set_parent(8'd255, 8'd0);
    set_parent(8'd7, 8'd7);
    lookup(8'd5, 8'd7);
    lookup(8'd7, 8'd0);
    lookup(8'd0, 8'd7);
    set_parent(8'd128, 8'd170);
    lookup(8'd128, 8'd85);
    drain();

    episode = 0;
    while (items_sent < ItemTarget) begin
      r = $urandom_range(0, 99);
      if (episode == 0) begin
        grow_vee(30, 30);
      end else if (episode == 1) begin
        grow_vee(31, 29);
      end else if (r < 5) begin
        grow_vee($urandom_range(1, 31), $urandom_range(1, 31));
      end else if (r < 60) begin
        grow_tree($urandom_range(2, 12));
        repeat ($urandom_range(2, 6)) lookup(pick_node(), pick_node());
      end else if (r < 72) begin
        if (nodes.size() > 0) begin
          set_parent(nodes[$urandom_range(0, nodes.size() - 1)],
                     nodes[$urandom_range(0, nodes.size() - 1)]);
        end
        repeat ($urandom_range(2, 4)) lookup(pick_node(), pick_node());
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(logic'($urandom_range(0, 1)), frame_t'($urandom), frame_t'($urandom),
                    frame_t'($urandom));
        end
      end
      if ($urandom_range(0, 9) == 0) drain();
      if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
      episode++;
    end

    start = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
